FILE: rtl/core/ed4_pkg.sv
// ============================================================================
// ed4_pkg
// Shared types, constants and helper functions for the 4-bit error-diffusion
// dither block.
// ============================================================================
package ed4_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int GREY_W     = 8;
    localparam int ERR_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);
    localparam logic [FW_W-1:0] FRAME_WIDTH_MIN  = FW_W'(2);
    localparam logic [FW_W-1:0] FRAME_WIDTH_MAX  = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN = FH_W'(1);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX = FH_W'(MAX_HEIGHT);

    // Diffusion weights in sixteenths.
    localparam logic [4:0] W_ZERO     = 5'd0;
    localparam logic [4:0] W_ALL      = 5'd16;
    localparam logic [4:0] W_MID_R    = 5'd7;
    localparam logic [4:0] W_MID_DR   = 5'd1;
    localparam logic [4:0] W_MID_D    = 5'd5;
    localparam logic [4:0] W_MID_DL   = 5'd3;
    localparam logic [4:0] W_LEFT_R   = 5'd8;
    localparam logic [4:0] W_LEFT_DR  = 5'd2;
    localparam logic [4:0] W_LEFT_D   = 5'd6;
    localparam logic [4:0] W_RIGHT_D  = 5'd10;
    localparam logic [4:0] W_RIGHT_DL = 5'd6;

    // Multiplier that turns a division by three of a 10-bit sum into a shift.
    localparam logic [20:0] DIV3_MUL   = 21'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] dithered_grey;
        logic       frame_end;
    } pix_out_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic bottom;
    } pos_flags_t;

    typedef struct packed {
        logic             left_en;
        logic [ERR_W-1:0] left_data;
        logic             tail_en;
        logic [ERR_W-1:0] tail_data;
    } err_wr_t;

    function automatic logic [GREY_W-1:0] grey_of(input pix_in_t p);
        logic [9:0]  sum;
        logic [20:0] prod;
        sum  = {2'b00, p.red} + {2'b00, p.green} + {2'b00, p.blue};
        prod = {11'b0, sum} * DIV3_MUL;
        return prod[DIV3_SHIFT +: GREY_W];
    endfunction

    // floor(weight * err / 16)
    function automatic logic [3:0] share(input logic [4:0] weight, input logic [3:0] err);
        logic [7:0] prod;
        prod = {3'b000, weight} * {4'b0000, err};
        return prod[7:4];
    endfunction

endpackage

FILE: rtl/core/error_diffusion_dither_4bit.sv
// ============================================================================
// error_diffusion_dither_4bit
// Floyd-Steinberg style dither of an RGB raster stream to 16 grey levels.
//
// Pixels arrive in raster order and each one yields one quantized grey item,
// with frame_end set on the last pixel of the frame. The block takes one item
// per clock while the output is not stalled by m_ready. The grey conversion
// and the line-memory read are registered on entry, and the error add,
// quantize and diffusion run in one pass into the output register. The
// error carried to the right and the partial errors for the next row live in
// flip-flops, so consecutive pixels see each other's error without a bubble.
// The next-row errors sit in a 1024 x 6 line memory with one write port and
// a registered read. frame_width and frame_height are clamped to 2..1024 and
// 1..4096; write them only while the block is idle.
// ============================================================================
module error_diffusion_dither_4bit
    import ed4_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_out_t              m_data
);

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              s1_valid_reg;
    logic [GREY_W-1:0] s1_grey_reg;
    logic [COL_W-1:0]  s1_col_reg;
    pos_flags_t        s1_flags_reg;

    logic [ERR_W-1:0]  carry_reg, carry_next;
    logic [ERR_W-1:0]  here_reg, here_next;
    logic [ERR_W-1:0]  ahead_reg, ahead_next;

    logic              m_valid_reg;
    pix_out_t          m_data_reg;

    logic [FW_W-1:0]   width_use;
    logic [FH_W-1:0]   height_use;
    logic [COL_W-1:0]  last_col_idx;
    logic [ROW_W-1:0]  last_row_idx;
    pos_flags_t        in_flags;
    logic              accept;
    logic              advance;
    logic [ERR_W-1:0]  pend;
    logic [GREY_W-1:0] quant;
    err_wr_t           err_wr;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < FRAME_WIDTH_MIN) begin
            width_use = FRAME_WIDTH_MIN;
        end else if (frame_width_reg > FRAME_WIDTH_MAX) begin
            width_use = FRAME_WIDTH_MAX;
        end else begin
            width_use = frame_width_reg;
        end
        if (frame_height_reg < FRAME_HEIGHT_MIN) begin
            height_use = FRAME_HEIGHT_MIN;
        end else if (frame_height_reg > FRAME_HEIGHT_MAX) begin
            height_use = FRAME_HEIGHT_MAX;
        end else begin
            height_use = frame_height_reg;
        end
        last_col_idx = COL_W'(width_use - FW_W'(1));
        last_row_idx = ROW_W'(height_use - FH_W'(1));
    end

    // -------------------------------------------------------------- handshake
    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // Position is known at acceptance, so the counters run on the input side.
    always_comb begin
        in_flags.first_row = (row_reg == '0);
        in_flags.first_col = (col_reg == '0);
        in_flags.last_col  = (col_reg >= last_col_idx);
        in_flags.bottom    = (row_reg >= last_row_idx);
        if (in_flags.last_col) begin
            col_next = '0;
            row_next = in_flags.bottom ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_grey_reg  <= grey_of(s_data);
            s1_col_reg   <= col_reg;
            s1_flags_reg <= in_flags;
        end
    end

    // ------------------------------------------------------------ line memory
    ed4_line_buf u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .wr_en     (advance && err_wr.left_en),
        .wr_addr   (s1_col_reg - COL_W'(1)),
        .wr_data   (err_wr.left_data),
        .tail_en   (advance && err_wr.tail_en),
        .tail_addr (s1_col_reg),
        .tail_data (err_wr.tail_data),
        .rd_data   (pend)
    );

    // -------------------------------------------------------------- diffusion
    ed4_diffuse u_diffuse (
        .grey            (s1_grey_reg),
        .pend            (pend),
        .carry           (carry_reg),
        .next_here       (here_reg),
        .next_ahead      (ahead_reg),
        .flags           (s1_flags_reg),
        .quant           (quant),
        .carry_next      (carry_next),
        .next_here_next  (here_next),
        .next_ahead_next (ahead_next),
        .err_wr          (err_wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg   <= '0;
            here_reg    <= '0;
            ahead_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                carry_reg <= carry_next;
                here_reg  <= here_next;
                ahead_reg <= ahead_next;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.dithered_grey <= quant;
            m_data_reg.frame_end     <= s1_flags_reg.last_col && s1_flags_reg.bottom;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // With the output register empty, the block can always take an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while the output register is empty");

    // A row ends with no error left to carry into the next row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_flags_reg.last_col |=>
            carry_reg == '0 && here_reg == '0 && ahead_reg == '0)
        else $error("error carried past the end of a row");

    // The counters restart after the last pixel of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_flags.last_col && in_flags.bottom |=>
            col_reg == '0 && row_reg == '0)
        else $error("position counters did not restart after frame end");

    // Delivered grey levels are multiples of sixteen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.dithered_grey[3:0] == 4'h0)
        else $error("delivered grey level is not quantized");
`endif

endmodule

FILE: rtl/core/ed4_diffuse.sv
// ============================================================================
// ed4_diffuse
// Adds the diffused error to one grey pixel, quantizes it and works out the
// shares of the residual error for the neighbors to the right and below.
// ============================================================================
module ed4_diffuse
    import ed4_pkg::*;
(
    input  logic [GREY_W-1:0] grey,
    input  logic [ERR_W-1:0]  pend,
    input  logic [ERR_W-1:0]  carry,
    input  logic [ERR_W-1:0]  next_here,
    input  logic [ERR_W-1:0]  next_ahead,
    input  pos_flags_t        flags,
    output logic [GREY_W-1:0] quant,
    output logic [ERR_W-1:0]  carry_next,
    output logic [ERR_W-1:0]  next_here_next,
    output logic [ERR_W-1:0]  next_ahead_next,
    output err_wr_t           err_wr
);

    logic [ERR_W-1:0]  pend_eff;
    logic [8:0]        sum;
    logic [GREY_W-1:0] sat;
    logic [3:0]        err;
    logic [4:0]        w_r, w_dr, w_d, w_dl;
    logic [ERR_W-1:0]  here;

    always_comb begin
        // The first row of a frame owes nothing from above.
        pend_eff = flags.first_row ? '0 : pend;
        sum      = {1'b0, grey} + {3'b000, pend_eff} + {3'b000, carry};
        sat      = sum[8] ? 8'hFF : sum[7:0];
        quant    = {sat[7:4], 4'h0};
        err      = sat[3:0];
    end

    always_comb begin
        if (flags.bottom) begin
            w_r  = flags.last_col ? W_ZERO : W_ALL;
            w_dr = W_ZERO;
            w_d  = W_ZERO;
            w_dl = W_ZERO;
        end else if (flags.first_col) begin
            w_r  = W_LEFT_R;
            w_dr = W_LEFT_DR;
            w_d  = W_LEFT_D;
            w_dl = W_ZERO;
        end else if (flags.last_col) begin
            w_r  = W_ZERO;
            w_dr = W_ZERO;
            w_d  = W_RIGHT_D;
            w_dl = W_RIGHT_DL;
        end else begin
            w_r  = W_MID_R;
            w_dr = W_MID_DR;
            w_d  = W_MID_D;
            w_dl = W_MID_DL;
        end
    end

    always_comb begin
        here              = next_ahead + {2'b00, share(w_d, err)};
        err_wr.left_en    = !flags.bottom && !flags.first_col;
        err_wr.left_data  = next_here + {2'b00, share(w_dl, err)};
        err_wr.tail_en    = !flags.bottom && flags.last_col;
        err_wr.tail_data  = here;
        if (flags.bottom || flags.last_col) begin
            next_here_next  = '0;
            next_ahead_next = '0;
        end else begin
            next_here_next  = here;
            next_ahead_next = {2'b00, share(w_dr, err)};
        end
        carry_next = flags.last_col ? '0 : {2'b00, share(w_r, err)};
    end

endmodule

FILE: rtl/core/ed4_line_buf.sv
// ============================================================================
// ed4_line_buf
// Line memory of errors owed to the next row, with a registered read and a
// forward path for writes that land on the entry being read.
// ============================================================================
module ed4_line_buf
    import ed4_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [ERR_W-1:0] wr_data,
    input  logic             tail_en,
    input  logic [COL_W-1:0] tail_addr,
    input  logic [ERR_W-1:0] tail_data,
    output logic [ERR_W-1:0] rd_data
);

    logic [ERR_W-1:0] mem [MAX_WIDTH];

    logic [ERR_W-1:0] rd_reg;
    logic [COL_W-1:0] cur_addr_reg;
    logic             ovr_valid_reg;
    logic [ERR_W-1:0] ovr_data_reg;
    logic             tail_pend_reg;
    logic [COL_W-1:0] tail_addr_reg;
    logic [ERR_W-1:0] tail_data_reg;

    logic             mw_en;
    logic [COL_W-1:0] mw_addr;
    logic [ERR_W-1:0] mw_data;

    // The last column writes two entries, the second through the tail registers;
    // the item that follows is always a first column, which writes nothing.
    always_comb begin
        mw_en   = tail_pend_reg || wr_en;
        mw_addr = tail_pend_reg ? tail_addr_reg : wr_addr;
        mw_data = tail_pend_reg ? tail_data_reg : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (mw_en) begin
            mem[mw_addr] <= mw_data;
        end
        if (rd_en) begin
            rd_reg       <= mem[rd_addr];
            cur_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        tail_addr_reg <= tail_addr;
        tail_data_reg <= tail_data;
        if (rd_en) begin
            ovr_data_reg <= mw_data;
        end else if (mw_en && mw_addr == cur_addr_reg) begin
            ovr_data_reg <= mw_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_pend_reg <= 1'b0;
            ovr_valid_reg <= 1'b0;
        end else begin
            tail_pend_reg <= tail_en;
            if (rd_en) begin
                ovr_valid_reg <= mw_en && mw_addr == rd_addr;
            end else if (mw_en && mw_addr == cur_addr_reg) begin
                ovr_valid_reg <= 1'b1;
            end
        end
    end

    assign rd_data = ovr_valid_reg ? ovr_data_reg : rd_reg;

endmodule
